>>> sv/modbus_rtu_register_slave_macros.svh
// Assertion macros for the Modbus RTU register slave.
`ifndef MODBUS_RTU_REGISTER_SLAVE_MACROS_SVH
`define MODBUS_RTU_REGISTER_SLAVE_MACROS_SVH
`ifndef SYNTH
`define MRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MRS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MRS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MRS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/mrs_pkg.sv
// Shared types and constants for the Modbus RTU register slave.
package mrs_pkg;
  localparam int REG_COUNT_DEF   = 16;
  localparam int FRAME_DEPTH_DEF = 16;

  localparam logic [1:0] KIND_RX    = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [7:0] FN_READ  = 8'h03;
  localparam logic [7:0] FN_WRITE = 8'h06;

  localparam logic [2:0] ST_READ_OK  = 3'd0;
  localparam logic [2:0] ST_WRITE_OK = 3'd1;
  localparam logic [2:0] ST_CRC_ERR  = 3'd2;
  localparam logic [2:0] ST_REJECT   = 3'd3;
  localparam logic [2:0] ST_BAD_LEN  = 3'd4;
  localparam logic [2:0] ST_LOCAL    = 3'd5;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // controller -> datapath
  typedef struct packed {
    logic       rx_byte;    // fold and store input byte
    logic       frame_clr;  // restart frame
    logic       loc_wr;
    logic       loc_rd;
    logic       chk_ld;     // latch frame decode
    logic       msk_step;   // advance mask scan
    logic       rsp_ld;     // start response
    logic       rsp_adv;    // next response byte
    logic       reg_commit; // write echo stores value
  } mrs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       len_bad;
    logic       hdr_bad;
    logic       crc_bad;
    logic       is_read;
    logic       rng_bad;
    logic       msk_bad;
    logic       msk_done;
    logic       rsp_last;
  } mrs_sts_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction
endpackage

>>> sv/mrs_datapath.sv
// Datapath: frame buffer, CRC, register file and response byte generator.
module mrs_datapath #(
  parameter int REG_COUNT   = mrs_pkg::REG_COUNT_DEF,
  parameter int FRAME_DEPTH = mrs_pkg::FRAME_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mrs_pkg::mrs_cmd_t   cmd,
  output mrs_pkg::mrs_sts_t   sts,
  input  logic [7:0]          device_address,
  input  logic [15:0]         active_mask,
  input  logic [7:0]          in_rx_byte,
  input  logic [3:0]          in_reg_index,
  input  logic [15:0]         in_reg_value,
  output logic [7:0]          rsp_byte,
  output logic [15:0]         loc_value
);
  localparam int CW = $clog2(FRAME_DEPTH + 1);
  localparam int FW = $clog2(FRAME_DEPTH);
  localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  logic [7:0]  frame_mem [FRAME_DEPTH];
  logic [15:0] regs_r [REG_COUNT];
  logic [15:0] crc_r;
  logic [CW-1:0] cnt_r;
  logic        ovf_r;
  logic [7:0]  b0_r, b1_r, b2_r, b3_r, b4_r, b5_r;

  // latched decode
  logic [15:0] a_r, n_r;
  logic [4:0]  scan_r;     // mask scan position
  logic [4:0]  scan_end_r;
  logic        msk_bad_r;

  // response
  logic        rd_mode_r;
  logic [5:0]  pos_r;
  logic [5:0]  len_r;
  logic [15:0] tcrc_r;
  logic [15:0] loc_value_r;
  logic [7:0]  echo_rd_r;
  logic [4:0]  ridx_r;

  always_ff @(posedge clk) begin
    if (cmd.rx_byte && cnt_r < CW'(FRAME_DEPTH)) begin
      frame_mem[cnt_r[FW-1:0]] <= in_rx_byte;
      case (cnt_r)
        CW'(0): b0_r <= in_rx_byte;
        CW'(1): b1_r <= in_rx_byte;
        CW'(2): b2_r <= in_rx_byte;
        CW'(3): b3_r <= in_rx_byte;
        CW'(4): b4_r <= in_rx_byte;
        CW'(5): b5_r <= in_rx_byte;
        default: ;
      endcase
    end
    echo_rd_r <= frame_mem[pos_r[FW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= mrs_pkg::CRC_INIT;
      cnt_r <= '0;
      ovf_r <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) regs_r[i] <= '0;
    end else begin
      if (cmd.frame_clr) begin
        crc_r <= mrs_pkg::CRC_INIT;
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end else if (cmd.rx_byte) begin
        crc_r <= mrs_pkg::crc_fold(crc_r, in_rx_byte);
        if (cnt_r < CW'(FRAME_DEPTH)) cnt_r <= cnt_r + 1'b1;
        else ovf_r <= 1'b1;
      end
      if (cmd.loc_wr && {1'b0, in_reg_index} < 5'(REG_COUNT))
        regs_r[in_reg_index[RW-1:0]] <= in_reg_value;
      if (cmd.reg_commit)
        regs_r[a_r[RW-1:0]] <= n_r;
    end
  end

  // decode checks (len/hdr/crc valid at frame end after last byte folded; rng/msk after chk_ld)
  wire [16:0] a_plus_n = {1'b0, a_r} + {1'b0, n_r};
  assign sts.len_bad  = ovf_r || cnt_r < CW'(6);
  assign sts.hdr_bad  = b0_r != device_address ||
                        (b1_r != mrs_pkg::FN_READ && b1_r != mrs_pkg::FN_WRITE);
  assign sts.crc_bad  = crc_r != 16'h0000;
  assign sts.is_read  = b1_r == mrs_pkg::FN_READ;
  assign sts.rng_bad  = rd_mode_r ? (n_r == 16'd0 || a_plus_n > 17'(REG_COUNT))
                                  : (a_r >= 16'(REG_COUNT));
  assign sts.msk_bad  = msk_bad_r;
  assign sts.msk_done = scan_r >= scan_end_r;
  assign sts.rsp_last = pos_r == len_r - 6'd1;

  always_ff @(posedge clk) begin
    if (cmd.chk_ld) begin
      a_r        <= {b2_r, b3_r};
      n_r        <= {b4_r, b5_r};
      rd_mode_r  <= b1_r == mrs_pkg::FN_READ;
      scan_r     <= b3_r[4:0];
      scan_end_r <= (b1_r == mrs_pkg::FN_READ) ? 5'(b3_r[4:0] + b5_r[4:0])
                                               : 5'(b3_r[4:0] + 5'd1);
      msk_bad_r  <= 1'b0;
    end else if (cmd.msk_step) begin
      if (!active_mask[scan_r[3:0]]) msk_bad_r <= 1'b1;
      scan_r <= scan_r + 5'd1;
    end
  end

  // response byte sequencer; steps to the next byte on each rsp_adv
  logic [7:0] nb;
  logic [15:0] rv;
  always_comb begin
    rv = regs_r[ridx_r[RW-1:0]];
    if (!rd_mode_r) nb = echo_rd_r;
    else if (pos_r == 6'd0) nb = device_address;
    else if (pos_r == 6'd1) nb = mrs_pkg::FN_READ;
    else if (pos_r == 6'd2) nb = {n_r[6:0], 1'b0};
    else if (pos_r == len_r - 6'd2) nb = tcrc_r[7:0];
    else if (pos_r == len_r - 6'd1) nb = tcrc_r[15:8];
    else nb = pos_r[0] ? rv[15:8] : rv[7:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.rsp_ld) begin
      pos_r  <= '0;
      ridx_r <= a_r[4:0];
      tcrc_r <= mrs_pkg::CRC_INIT;
      len_r  <= rd_mode_r ? 6'(6'd5 + {n_r[4:0], 1'b0}) : 6'(cnt_r);
    end else if (cmd.rsp_adv) begin
      if (pos_r < len_r - 6'd2) tcrc_r <= mrs_pkg::crc_fold(tcrc_r, nb);
      if (pos_r >= 6'd3 && !pos_r[0]) ridx_r <= ridx_r + 5'd1;
      pos_r <= pos_r + 6'd1;
    end
    if (cmd.loc_rd)
      loc_value_r <= ({1'b0, in_reg_index} < 5'(REG_COUNT)) ? regs_r[in_reg_index[RW-1:0]]
                                                              : 16'd0;
  end

  assign rsp_byte  = nb;
  assign loc_value = loc_value_r;
endmodule

>>> sv/mrs_ctrl.sv
// Controller: sequences frame checks, responses and local accesses.
module mrs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic              in_frame_end,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              o_tx_valid,
  output logic              o_tx_last,
  output logic [2:0]        o_status,
  output logic              o_use_loc,
  output mrs_pkg::mrs_cmd_t cmd,
  input  mrs_pkg::mrs_sts_t sts
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHK   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_PREP  = 3'd3;
  localparam logic [2:0] S_STRM  = 3'd4;
  localparam logic [2:0] S_ONE   = 3'd5;
  localparam logic [2:0] S_PREP2 = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [2:0] st_r, st_nxt;
  logic       loc_r, loc_nxt;
  logic       acc;

  assign in_ready = state_r == S_IDLE;
  assign acc = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    st_nxt = st_r;
    loc_nxt = loc_r;
    case (state_r)
      S_IDLE: if (acc) begin
        case (in_kind)
          mrs_pkg::KIND_RX: begin
            cmd.rx_byte = 1'b1;
            if (in_frame_end) state_nxt = S_CHK;
          end
          mrs_pkg::KIND_WRITE: begin
            cmd.loc_wr = 1'b1; st_nxt = mrs_pkg::ST_LOCAL; loc_nxt = 1'b0;
            state_nxt = S_ONE;
          end
          mrs_pkg::KIND_READ: begin
            cmd.loc_rd = 1'b1; st_nxt = mrs_pkg::ST_LOCAL; loc_nxt = 1'b1;
            state_nxt = S_ONE;
          end
          default: ;
        endcase
      end
      S_CHK: begin
        loc_nxt = 1'b0;
        cmd.chk_ld = 1'b1;
        if (sts.len_bad) begin
          st_nxt = mrs_pkg::ST_BAD_LEN; state_nxt = S_ONE; cmd.frame_clr = 1'b1;
        end else if (sts.hdr_bad) begin
          st_nxt = mrs_pkg::ST_REJECT; state_nxt = S_ONE; cmd.frame_clr = 1'b1;
        end else if (sts.crc_bad) begin
          st_nxt = mrs_pkg::ST_CRC_ERR; state_nxt = S_ONE; cmd.frame_clr = 1'b1;
        end else begin
          st_nxt = sts.is_read ? mrs_pkg::ST_READ_OK : mrs_pkg::ST_WRITE_OK;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.rng_bad || sts.msk_bad) begin
          st_nxt = mrs_pkg::ST_REJECT; state_nxt = S_ONE; cmd.frame_clr = 1'b1;
        end else if (sts.msk_done) begin
          state_nxt = S_PREP; cmd.rsp_ld = 1'b1;
          cmd.reg_commit = st_r == mrs_pkg::ST_WRITE_OK;
        end else cmd.msk_step = 1'b1;
      end
      S_PREP: state_nxt = S_PREP2; // echo memory read latency
      S_PREP2: state_nxt = S_STRM;
      S_STRM: if (out_ready) begin
        cmd.rsp_adv = 1'b1;
        if (sts.rsp_last) begin
          state_nxt = S_IDLE; cmd.frame_clr = 1'b1;
        end else state_nxt = S_PREP2;
      end
      S_ONE: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r <= mrs_pkg::ST_READ_OK;
      loc_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      st_r <= st_nxt;
      loc_r <= loc_nxt;
    end
  end

  assign out_valid  = state_r == S_STRM || state_r == S_ONE;
  assign o_tx_valid = state_r == S_STRM;
  assign o_tx_last  = state_r == S_ONE || sts.rsp_last;
  assign o_status   = st_r;
  assign o_use_loc  = loc_r;
endmodule

>>> sv/modbus_rtu_register_slave.sv
// Modbus RTU register slave (functions 03 and 06) with local register access.
// Frame bytes are taken every cycle while idle. At frame end, a length, header or CRC
// error is reported from S_CHK; otherwise range and mask checks step through S_SCAN one
// register at a time, then S_PREP and S_PREP2 precede the first response byte. Response
// bytes alternate S_STRM with S_PREP2 (registered frame buffer read); a local access result
// follows in the cycle after accept. Sync reset clears control, config, CRC, count, regs.
`include "modbus_rtu_register_slave_macros.svh"
module modbus_rtu_register_slave #(
  parameter int REG_COUNT   = mrs_pkg::REG_COUNT_DEF,
  parameter int FRAME_DEPTH = mrs_pkg::FRAME_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_frame_end,
  input  logic [3:0]  in_reg_index,
  input  logic [15:0] in_reg_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_tx_last,
  output logic [2:0]  out_status,
  output logic [15:0] out_read_value
);
  logic [7:0]  dev_addr_r;
  logic [15:0] mask_r;
  mrs_pkg::mrs_cmd_t cmd;
  mrs_pkg::mrs_sts_t sts;
  logic [7:0]  rsp_byte;
  logic [15:0] loc_value;
  logic        use_loc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= 8'd1;
      mask_r <= 16'd0;
    end else if (cfg_we) begin
      if (!cfg_index) dev_addr_r <= cfg_wdata[7:0];
      else mask_r <= cfg_wdata;
    end
  end

  mrs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_frame_end,
    .out_valid, .out_ready,
    .o_tx_valid(out_tx_valid), .o_tx_last(out_tx_last), .o_status(out_status),
    .o_use_loc(use_loc), .cmd, .sts
  );

  mrs_datapath #(.REG_COUNT(REG_COUNT), .FRAME_DEPTH(FRAME_DEPTH)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .device_address(dev_addr_r), .active_mask(mask_r),
    .in_rx_byte, .in_reg_index, .in_reg_value,
    .rsp_byte, .loc_value
  );

  // byte is zero on status-only transactions
  assign out_tx_byte    = out_tx_valid ? rsp_byte : 8'h00;
  assign out_read_value = use_loc ? loc_value : 16'h0000;

  `MRS_ASSERT_IMP(a_no_in_while_out, clk, rst_n, out_valid, !in_ready)
  `MRS_ASSERT_IMP(a_err_is_last, clk, rst_n, out_valid && !out_tx_valid, out_tx_last)
  `MRS_ASSERT_IMP(a_byte_zero, clk, rst_n, out_valid && !out_tx_valid, out_tx_byte == 8'h00)
endmodule
